[sv/iau_pkg.sv]
package iau_pkg;

  // Fixed field width of every endpoint on the ports
  localparam int WORD_BITS = 32;

  // Action codes carried by a request
  localparam logic [2:0] ACT_ADD   = 3'd0;
  localparam logic [2:0] ACT_SUB   = 3'd1;
  localparam logic [2:0] ACT_MUL   = 3'd2;
  localparam logic [2:0] ACT_DIV   = 3'd3;
  localparam logic [2:0] ACT_SCALE = 3'd4;
  localparam logic [2:0] ACT_SDIV  = 3'd5;

  // Operation kinds after classification
  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_SMUL = 3'd4;
  localparam logic [2:0] KIND_SDIV = 3'd5;
  localparam logic [2:0] KIND_PASS = 3'd6;

  typedef struct packed {
    logic [2:0]                  action;
    logic signed [WORD_BITS-1:0] left_low;
    logic signed [WORD_BITS-1:0] left_high;
    logic signed [WORD_BITS-1:0] right_low;
    logic signed [WORD_BITS-1:0] right_high;
  } req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_low;
    logic signed [WORD_BITS-1:0] result_high;
    logic                        zero_divisor;
    logic                        saturated;
  } rsp_t;

  // Classified request held in the queue
  typedef struct packed {
    logic [2:0]           kind;
    logic                 zdiv;
    logic [WORD_BITS-1:0] ll;
    logic [WORD_BITS-1:0] lh;
    logic [WORD_BITS-1:0] rl;
    logic [WORD_BITS-1:0] rh;
  } entry_t;

endpackage

[sv/iau_front.sv]
module iau_front (
  input  logic           req_valid,
  output logic           req_ready,
  input  iau_pkg::req_t  req,
  input  logic           full,
  output logic           push,
  output iau_pkg::entry_t entry
);
  import iau_pkg::*;

  localparam int W = WORD_BITS;

  logic rl_zero, rh_zero;

  assign req_ready = !full;
  assign push      = req_valid && !full;
  assign rl_zero   = (req.right_low == '0);
  assign rh_zero   = (req.right_high == '0);

  // Classify the action and detect a divisor that contains zero
  always_comb begin
    entry.ll   = req.left_low;
    entry.lh   = req.left_high;
    entry.rl   = req.right_low;
    entry.rh   = req.right_high;
    entry.zdiv = 1'b0;
    case (req.action)
      ACT_ADD:   entry.kind = KIND_ADD;
      ACT_SUB:   entry.kind = KIND_SUB;
      ACT_MUL:   entry.kind = KIND_MUL;
      ACT_SCALE: entry.kind = KIND_SMUL;
      ACT_DIV: begin
        if (rl_zero || rh_zero || (req.right_low[W-1] != req.right_high[W-1])) begin
          entry.kind = KIND_PASS;
          entry.zdiv = 1'b1;
        end else begin
          entry.kind = KIND_DIV;
        end
      end
      ACT_SDIV: begin
        if (rl_zero) begin
          entry.kind = KIND_PASS;
          entry.zdiv = 1'b1;
        end else begin
          entry.kind = KIND_SDIV;
        end
      end
      default:   entry.kind = KIND_PASS;
    endcase
  end

endmodule

[sv/iau_queue.sv]
module iau_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  iau_pkg::entry_t wr,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output iau_pkg::entry_t head
);
  import iau_pkg::*;

  entry_t     mem [2];
  logic [1:0] count;
  logic       wr_ptr, rd_ptr;
  logic       push_ok, pop_ok;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_ok) wr_ptr <= !wr_ptr;
      if (pop_ok)  rd_ptr <= !rd_ptr;
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push_ok) mem[wr_ptr] <= wr;
  end

endmodule

[sv/iau_back.sv]
module iau_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  iau_pkg::entry_t head,
  output logic            pop,
  output logic            rsp_valid,
  output iau_pkg::rsp_t   rsp,
  input  logic            rsp_ready
);
  import iau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int QB = W + FRACTION_BITS;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 1;
  localparam logic signed [XW-1:0] MAXV  = $signed((XW'(1) << (W - 1)) - XW'(1));
  localparam logic signed [XW-1:0] MINV  = ~MAXV;
  localparam logic signed [XW-1:0] RMASK = $signed((XW'(1) << FRACTION_BITS) - XW'(1));

  typedef struct packed {
    logic                 vld;
    logic [2:0]           kind;
    logic                 zdiv;
    logic [W-1:0]         ll;
    logic [W-1:0]         lh;
    logic [W-1:0]         rl;
    logic [W-1:0]         rh;
    logic [3:0][PW-1:0]   prod;
    logic [3:0][QB-1:0]   nq;
    logic [3:0][W-1:0]    rem;
    logic [3:0][W-1:0]    dv;
    logic [3:0]           neg;
  } st_t;

  typedef struct packed {
    logic                 vld;
    logic [2:0]           kind;
    logic                 zdiv;
    logic [W-1:0]         ll;
    logic [W-1:0]         lh;
    logic [W-1:0]         rl;
    logic [W-1:0]         rh;
    logic [3:0][XW-1:0]   fl;
    logic [3:0][XW-1:0]   ce;
  } rd_t;

  st_t  pipe [QB+1];
  st_t  step_st [QB];
  st_t  entry_st;
  rd_t  rnd, rnd_next;
  rsp_t rsp_next;
  logic adv;

  logic [3:0][W-1:0]      xs, ys;
  logic signed [PW-1:0]   xe [4];
  logic signed [PW-1:0]   ye [4];
  logic signed [XW-1:0]   pe [4];
  logic signed [XW-1:0]   qx [4];
  logic signed [XW-1:0]   qi [4];
  logic signed [XW-1:0]   flv [4];
  logic signed [XW-1:0]   cev [4];
  logic signed [XW-1:0]   m01, m23, c01, c23, lo, hi, ell, elh, erl, erh;
  logic                   sat_l, sat_h;

  assign adv = !rsp_valid || rsp_ready;
  assign pop = adv && head_valid;

  // One restoring division step on every lane
  function automatic st_t dstep(st_t s);
    st_t        r;
    logic [W:0] rs;
    logic       ge;
    r = s;
    for (int i = 0; i < 4; i++) begin
      rs = {s.rem[i], s.nq[i][QB-1]};
      ge = (rs >= {1'b0, s.dv[i]});
      r.rem[i] = ge ? W'(rs - {1'b0, s.dv[i]}) : rs[W-1:0];
      r.nq[i]  = {s.nq[i][QB-2:0], ge};
    end
    return r;
  endfunction

  // Entry: lane operands, products and divider setup
  always_comb begin
    xs[0] = head.ll;
    xs[1] = head.ll;
    xs[2] = head.lh;
    xs[3] = head.lh;
    ys[0] = head.rl;
    ys[2] = head.rl;
    ys[1] = (head.kind inside {KIND_SMUL, KIND_SDIV}) ? head.rl : head.rh;
    ys[3] = ys[1];
    entry_st.vld  = head_valid;
    entry_st.kind = head.kind;
    entry_st.zdiv = head.zdiv;
    entry_st.ll   = head.ll;
    entry_st.lh   = head.lh;
    entry_st.rl   = head.rl;
    entry_st.rh   = head.rh;
    for (int i = 0; i < 4; i++) begin
      xe[i] = PW'($signed(xs[i]));
      ye[i] = PW'($signed(ys[i]));
      entry_st.prod[i] = xe[i] * ye[i];
      entry_st.nq[i]   = QB'(xs[i][W-1] ? W'(-xs[i]) : xs[i]) << FRACTION_BITS;
      entry_st.rem[i]  = '0;
      entry_st.dv[i]   = ys[i][W-1] ? W'(-ys[i]) : ys[i];
      entry_st.neg[i]  = xs[i][W-1] ^ ys[i][W-1];
    end
  end

  // Divider stages
  for (genvar k = 0; k < QB; k++) begin : g_step
    always_comb step_st[k] = dstep(pipe[k]);
  end

  // Outward rounding of each lane
  always_comb begin
    rnd_next.vld  = pipe[QB].vld;
    rnd_next.kind = pipe[QB].kind;
    rnd_next.zdiv = pipe[QB].zdiv;
    rnd_next.ll   = pipe[QB].ll;
    rnd_next.lh   = pipe[QB].lh;
    rnd_next.rl   = pipe[QB].rl;
    rnd_next.rh   = pipe[QB].rh;
    for (int i = 0; i < 4; i++) begin
      pe[i] = XW'($signed(pipe[QB].prod[i]));
      qx[i] = $signed(XW'(pipe[QB].nq[i]));
      qi[i] = qx[i] + $signed(XW'(|pipe[QB].rem[i]));
      if (pipe[QB].kind inside {KIND_DIV, KIND_SDIV}) begin
        rnd_next.fl[i] = pipe[QB].neg[i] ? -qi[i] : qx[i];
        rnd_next.ce[i] = pipe[QB].neg[i] ? -qx[i] : qi[i];
      end else begin
        rnd_next.fl[i] = pe[i] >>> FRACTION_BITS;
        rnd_next.ce[i] = (pe[i] + RMASK) >>> FRACTION_BITS;
      end
    end
  end

  // Result select and clamp
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      flv[i] = $signed(rnd.fl[i]);
      cev[i] = $signed(rnd.ce[i]);
    end
    ell = XW'($signed(rnd.ll));
    elh = XW'($signed(rnd.lh));
    erl = XW'($signed(rnd.rl));
    erh = XW'($signed(rnd.rh));
    m01 = (flv[1] < flv[0]) ? flv[1] : flv[0];
    m23 = (flv[3] < flv[2]) ? flv[3] : flv[2];
    c01 = (cev[1] > cev[0]) ? cev[1] : cev[0];
    c23 = (cev[3] > cev[2]) ? cev[3] : cev[2];
    case (rnd.kind)
      KIND_ADD: begin
        lo = ell + erl;
        hi = elh + erh;
      end
      KIND_SUB: begin
        lo = ell - erh;
        hi = elh - erl;
      end
      KIND_MUL, KIND_DIV, KIND_SMUL, KIND_SDIV: begin
        lo = (m23 < m01) ? m23 : m01;
        hi = (c23 > c01) ? c23 : c01;
      end
      default: begin
        lo = ell;
        hi = elh;
      end
    endcase
    sat_l = (lo > MAXV) || (lo < MINV);
    sat_h = (hi > MAXV) || (hi < MINV);
    rsp_next.result_low   = sat_l ? ((lo > MAXV) ? MAXV[W-1:0] : MINV[W-1:0]) : lo[W-1:0];
    rsp_next.result_high  = sat_h ? ((hi > MAXV) ? MAXV[W-1:0] : MINV[W-1:0]) : hi[W-1:0];
    rsp_next.zero_divisor = rnd.zdiv;
    rsp_next.saturated    = sat_l || sat_h;
  end

  // Pipeline registers, all advancing together while the output can move
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) pipe[k].vld <= 1'b0;
      rnd.vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      pipe[0] <= entry_st;
      for (int k = 0; k < QB; k++) pipe[k+1] <= step_st[k];
      rnd       <= rnd_next;
      rsp_valid <= rnd.vld;
      rsp       <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_zdiv_no_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.zero_divisor |-> !rsp.saturated)
    else $error("zero divisor result marked saturated");
  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    rnd.vld && adv |=> rsp_valid)
    else $error("rounded item lost before output");
  a_zdiv_pass: assert property (@(posedge clk) disable iff (rst)
    pipe[0].vld && pipe[0].zdiv |-> pipe[0].kind == KIND_PASS)
    else $error("zero divisor item not passed through");
`endif

endmodule

[sv/interval_arithmetic_unit.sv]
// Interval arithmetic unit, signed fixed point with FRACTION_BITS fraction bits.
// Requests pass through a two-entry queue that decouples intake, an entry
// stage, the one-bit-per-stage pipelined divider lanes, a rounding stage
// and an output register. One request per cycle unless the output stalls.
// Reset (rst, synchronous, active high) empties the queue and the pipeline.
module interval_arithmetic_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  iau_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output iau_pkg::rsp_t  rsp
);
  import iau_pkg::*;

  entry_t entry, head;
  logic   push, full, pop, head_valid;

  iau_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .full      (full),
    .push      (push),
    .entry     (entry)
  );

  iau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr         (entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  iau_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp),
    .rsp_ready  (rsp_ready)
  );

endmodule
